### sv/mmc_pkg.sv
`default_nettype none

package mmc_pkg;

    // Default sizing of the class counter store
    localparam int MAX_CLASSES_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 17;

    // Fixed field widths
    localparam int LABEL_W = 7;

    // Class count in use after reset
    localparam logic [LABEL_W-1:0] LEVELS_RESET = 7'd2;

endpackage

`default_nettype wire

### sv/masked_majority_class_unit.sv
`default_nettype none
// An uncounted record leaves the input free; a counted record is read, then stalls the input
// while its counter is written back with a saturating increment through the memory ports.
// A last record adds a scan of the L class levels in use (one counter per cycle through the
// shared compare), a drain and a finish step, then a clear pass over all MAX_CLASSES counters
// before the next request. Reset: asynchronous, active low; counters are cleared by that pass
// after reset, during which no request is accepted (configuration writes are taken at any time).
module masked_majority_class_unit
    import mmc_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [LABEL_W-1:0] cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [LABEL_W-1:0] class_label,
    input  wire logic               record_covered,
    input  wire logic               last_record,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [LABEL_W-1:0] majority_class,
    output logic                    label_error
);

    localparam int AW = $clog2(MAX_CLASSES);
    localparam int CW = (AW + 1 > LABEL_W) ? AW + 1 : LABEL_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_INC    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [LABEL_W-1:0]     levels_reg;
    logic [2:0]             state_reg, state_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic                   last_reg, last_next;
    logic                   err_reg, err_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0]     majority_reg, majority_next;
    logic                   lerr_reg, lerr_next;
    logic                   cmp_vld_reg;
    logic [AW-1:0]          cmp_idx_reg;
    logic [COUNT_WIDTH-1:0] best_cnt_reg;
    logic [AW-1:0]          best_idx_reg;

    logic [CW-1:0]          lab_ext, lvl_ext, eff_m1_w, slot_w;
    logic [AW-1:0]          eff_m1, slot;
    logic                   label_ok;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [COUNT_WIDTH-1:0] mem_wdata, mem_rdata, cnt_inc;
    logic [CW-1:0]          best_class_w;

    // Clamp the class count and check the label against it
    always_comb
    begin
        lab_ext = CW'(class_label);
        lvl_ext = CW'(levels_reg);
        if (lvl_ext == '0)
        begin
            eff_m1_w = '0;
        end
        else if (lvl_ext > CW'(MAX_CLASSES))
        begin
            eff_m1_w = CW'(MAX_CLASSES - 1);
        end
        else
        begin
            eff_m1_w = lvl_ext - CW'(1);
        end
        slot_w   = lab_ext - CW'(1);
        label_ok = (lab_ext != '0) && (slot_w <= eff_m1_w);
        eff_m1   = eff_m1_w[AW-1:0];
        slot     = slot_w[AW-1:0];
    end

    // Saturating increment of the counter just read
    assign cnt_inc = (mem_rdata == {COUNT_WIDTH{1'b1}}) ? mem_rdata
                                                        : mem_rdata + COUNT_WIDTH'(1);

    // Share the memory's one read and one write port between count, scan and clear
    assign mem_we    = (state_reg == ST_INC) || (state_reg == ST_CLEAR);
    assign mem_waddr = (state_reg == ST_CLEAR) ? idx_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : cnt_inc;
    assign mem_raddr = (state_reg == ST_IDLE) ? slot : idx_reg;

    mmc_count_mem #(
        .DEPTH (MAX_CLASSES),
        .WIDTH (COUNT_WIDTH)
    ) u_count_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign best_class_w = CW'(best_idx_reg) + CW'(1);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && out_stall;
        majority_next  = majority_reg;
        lerr_next      = lerr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(MAX_CLASSES - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next = slot;
                    last_next = last_record;
                    if (!record_covered && !label_ok)
                    begin
                        err_next = 1'b1;
                    end
                    if (!record_covered && label_ok)
                    begin
                        state_next = ST_INC;
                    end
                    else if (last_record)
                    begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_INC:
            begin
                if (last_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == eff_m1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    majority_next  = best_class_w[LABEL_W-1:0];
                    lerr_next      = err_reg;
                    err_next       = 1'b0;
                    idx_next       = '0;
                    state_next     = ST_CLEAR;
                end
            end
            default:
            begin
                idx_next   = '0;
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            levels_reg    <= LEVELS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            cmp_vld_reg   <= (state_reg == ST_SCAN);
            if (cfg_we)
            begin
                levels_reg <= cfg_wdata;
            end
        end
    end

    // Hold payload and running maximum
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        majority_reg <= majority_next;
        lerr_reg     <= lerr_next;
        cmp_idx_reg  <= idx_reg;
        if (cmp_vld_reg && ((cmp_idx_reg == '0) || (mem_rdata > best_cnt_reg)))
        begin
            best_cnt_reg <= mem_rdata;
            best_idx_reg <= cmp_idx_reg;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign majority_class = majority_reg;
    assign label_error    = lerr_reg;

`ifndef SYNTHESIS
    a_inc_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INC |=> (state_reg == ST_IDLE || state_reg == ST_SCAN))
        else $error("increment did not return to idle or scan");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> idx_reg <= eff_m1)
        else $error("scan index beyond class count");

    a_clear_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && idx_reg == AW'(MAX_CLASSES - 1)) |=> state_reg == ST_IDLE)
        else $error("clear pass did not end in idle");
`endif

endmodule

`default_nettype wire

### sv/mmc_count_mem.sv
`default_nettype none

module mmc_count_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 17
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one counter per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### dv/masked_majority_class_unit_test.sv
`default_nettype none

module masked_majority_class_unit_test;
    import mmc_pkg::*;

    localparam int unsigned TALLY_MAX = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int SETTLE_CYCLES = 150;

    typedef enum logic { ROW_RECORD, ROW_LEVELS } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [LABEL_W-1:0] value;
        logic               covered;
        logic               last;
        logic               pinned;
        logic [LABEL_W-1:0] pin_class;
        logic               pin_error;
    } plan_row_t;

    typedef struct packed {
        logic [LABEL_W-1:0] winner;
        logic               stray;
    } verdict_t;

    localparam int PLAN_ROWS = 27;

    // Directed plan: extremes, range errors, ties, clamped levels, levels changed mid-batch
    plan_row_t opening_plan [PLAN_ROWS] = '{
        '{ROW_RECORD, 7'd1,   1'b0, 1'b1, 1'b1, 7'd1,  1'b0},
        '{ROW_RECORD, 7'd2,   1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd2,   1'b0, 1'b1, 1'b1, 7'd2,  1'b0},
        '{ROW_RECORD, 7'd2,   1'b1, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd127, 1'b1, 1'b1, 1'b1, 7'd1,  1'b0},
        '{ROW_RECORD, 7'd0,   1'b0, 1'b1, 1'b1, 7'd1,  1'b1},
        '{ROW_RECORD, 7'd3,   1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd2,   1'b0, 1'b1, 1'b1, 7'd2,  1'b1},
        '{ROW_LEVELS, 7'd64,  1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd64,  1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd127, 1'b0, 1'b1, 1'b1, 7'd64, 1'b1},
        '{ROW_RECORD, 7'd5,   1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd3,   1'b0, 1'b1, 1'b1, 7'd3,  1'b0},
        '{ROW_LEVELS, 7'd0,   1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd1,   1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd2,   1'b0, 1'b1, 1'b1, 7'd1,  1'b1},
        '{ROW_LEVELS, 7'd127, 1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd64,  1'b0, 1'b1, 1'b1, 7'd64, 1'b0},
        '{ROW_RECORD, 7'd65,  1'b0, 1'b1, 1'b1, 7'd1,  1'b1},
        '{ROW_LEVELS, 7'd64,  1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd40,  1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd40,  1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_LEVELS, 7'd8,   1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd4,   1'b0, 1'b1, 1'b1, 7'd4,  1'b0},
        '{ROW_LEVELS, 7'd64,  1'b0, 1'b0, 1'b0, 7'd0,  1'b0},
        '{ROW_RECORD, 7'd2,   1'b0, 1'b1, 1'b1, 7'd2,  1'b0},
        '{ROW_LEVELS, 7'd1,   1'b0, 1'b0, 1'b0, 7'd0,  1'b0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [LABEL_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [LABEL_W-1:0] class_label = '0;
    logic               record_covered = 1'b0;
    logic               last_record = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [LABEL_W-1:0] majority_class;
    logic               label_error;

    // Vote predictor state
    int unsigned        class_tally [MAX_CLASSES_DEF];
    logic               stray_label = 1'b0;
    logic [LABEL_W-1:0] levels_cfg = LEVELS_RESET;

    verdict_t           awaited_majority [$];
    int                 fault_count = 0;
    int                 send_gap_pct = 12;
    int                 drain_stall_pct = 67;

    masked_majority_class_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .class_label    (class_label),
        .record_covered (record_covered),
        .last_record    (last_record),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .majority_class (majority_class),
        .label_error    (label_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < MAX_CLASSES_DEF; i++)
        begin
            class_tally[i] = 0;
        end
    end

    // Clamp the levels register to 1..MAX_CLASSES
    function automatic int levels_in_force();
        if (levels_cfg == 0)
            return 1;
        if (levels_cfg > MAX_CLASSES_DEF)
            return MAX_CLASSES_DEF;
        return int'(levels_cfg);
    endfunction

    // Count one record; on a last record pick the winner and clear the batch
    function automatic bit tally_record(input logic [LABEL_W-1:0] lbl, input logic cov,
                                        input logic lst, output verdict_t v);
        int lv;
        int best;
        lv = levels_in_force();
        v = '0;
        if (!cov)
        begin
            if (lbl >= 1 && int'(lbl) <= lv)
            begin
                if (class_tally[lbl-1] < TALLY_MAX)
                    class_tally[lbl-1]++;
            end
            else
                stray_label = 1'b1;
        end
        if (!lst)
            return 1'b0;
        best = 0;
        for (int i = 1; i < lv; i++)
        begin
            if (class_tally[i] > class_tally[best])
                best = i;
        end
        v.winner = LABEL_W'(best + 1);
        v.stray = stray_label;
        for (int i = 0; i < MAX_CLASSES_DEF; i++)
        begin
            class_tally[i] = 0;
        end
        stray_label = 1'b0;
        return 1'b1;
    endfunction

    // Present one request, hold it until taken, then predict; entered and left at negedge
    task automatic send_record(input logic [LABEL_W-1:0] lbl, input logic cov, input logic lst,
                               input logic pinned = 1'b0,
                               input logic [LABEL_W-1:0] pin_class = '0,
                               input logic pin_error = 1'b0);
        verdict_t v;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        class_label <= lbl;
        record_covered <= cov;
        last_record <= lst;
        do
            @(posedge clk);
        while (in_stall);
        if (tally_record(lbl, cov, lst, v))
        begin
            if (pinned)
            begin
                v.winner = pin_class;
                v.stray = pin_error;
            end
            awaited_majority.push_back(v);
        end
        @(negedge clk);
    endtask

    // Drain the block, let the clear pass finish, then write the levels register
    task automatic write_levels(input logic [LABEL_W-1:0] value);
        in_valid <= 1'b0;
        while (awaited_majority.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        levels_cfg = value;
    endtask

    // Random batch with labels biased toward the low classes so votes collide
    task automatic send_batch(output int sent);
        int n;
        int lv;
        int low_span;
        int pick;
        logic [LABEL_W-1:0] lbl;
        n = ($urandom_range(99) < 5) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        lv = levels_in_force();
        low_span = (lv < 4) ? lv : 4;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                lbl = LABEL_W'($urandom_range(1, low_span));
            else if (pick < 88)
                lbl = LABEL_W'($urandom_range(1, lv));
            else if (pick < 94)
                lbl = '0;
            else
                lbl = LABEL_W'($urandom_range(lv + 1, 127));
            send_record(lbl, $urandom_range(99) < 20, k == n - 1);
        end
        sent = n;
    endtask

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < drain_stall_pct);
    end

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_majority.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: class %0d error %0b", majority_class,
                             label_error);
            end
            else
            begin
                want = awaited_majority.pop_front();
                if (want.winner !== majority_class || want.stray !== label_error)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: class exp %0d got %0d, error exp %0b got %0b",
                                 want.winner, majority_class, want.stray, label_error);
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int phase_items;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (opening_plan[r].kind == ROW_LEVELS)
                write_levels(opening_plan[r].value);
            else
                send_record(opening_plan[r].value, opening_plan[r].covered,
                            opening_plan[r].last, opening_plan[r].pinned,
                            opening_plan[r].pin_class, opening_plan[r].pin_error);
        end

        // Random part, two settings per idling mode
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_levels(7'd4);
                1: write_levels(7'd64);
                2: write_levels(7'd1);
                3: write_levels(LABEL_W'($urandom_range(2, 63)));
                4: write_levels(7'd2);
                default: write_levels(LABEL_W'($urandom_range(0, 127)));
            endcase
            send_gap_pct = (ph < 2) ? 12 : (ph < 4) ? 67 : 0;
            drain_stall_pct = (ph < 2) ? 67 : (ph < 4) ? 12 : 0;
            phase_items = 0;
            while (phase_items < 108)
            begin
                send_batch(sent);
                phase_items += sent;
                // Hold off now and then until every result is back
                if ($urandom_range(14) == 0)
                begin
                    in_valid <= 1'b0;
                    while (awaited_majority.size() != 0)
                        @(negedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        while (awaited_majority.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (awaited_majority.size() != 0)
            fault_count++;
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
